// ===== hdl/itoa_pkg.sv =====
package itoa_pkg;

  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] DEC_DIGITS = 6'd10;
  localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CHAR_A = 8'h61;  // 'a'

  typedef struct packed {
    logic [63:0] value;
    logic        signed_mode;
    logic [5:0]  radix;
  } in_word_t;

  typedef struct packed {
    logic [7:0] character;
    logic       negative;
    logic       last;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic digit_wr;
    logic emit_rd;
    logic emit_ld;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic quot_zero;
    logic emit_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [7:0] digit_char(input logic [5:0] d);
    logic [7:0] ch;
    if (d >= DEC_DIGITS) begin
      ch = CHAR_A + {2'b00, d - DEC_DIGITS};
    end else begin
      ch = CHAR_ZERO + {2'b00, d};
    end
    return ch;
  endfunction

endpackage

// ===== hdl/itoa_ctrl.sv =====
module itoa_ctrl #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  itoa_pkg::dp_status_t  status_i,
  output itoa_pkg::dp_cmd_t     cmd_o
);

  localparam int SW = $clog2(VALUE_WIDTH);
  localparam logic [SW-1:0] LAST_STEP = SW'(VALUE_WIDTH - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_DIGIT = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [SW-1:0] step_q, step_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        cmd_o.digit_wr = 1'b1;
        step_d         = '0;
        state_d        = status_i.quot_zero ? ST_READ : ST_DIV;
      end
      ST_READ: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = ST_LOAD;
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.emit_ld = 1'b1;
          state_d       = status_i.emit_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== hdl/itoa_dpath.sv =====
module itoa_dpath #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  itoa_pkg::in_word_t    in_word_i,
  input  itoa_pkg::dp_cmd_t     cmd_i,
  output itoa_pkg::dp_status_t  status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output itoa_pkg::out_word_t   out_word_o
);

  localparam int W  = VALUE_WIDTH;
  localparam int IW = $clog2(W);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quot_q, quot_d;
  logic [5:0]    rem_q, rem_d;
  logic [5:0]    radix_q;
  logic          neg_q;
  logic [CW-1:0] wr_cnt_q;
  logic [IW-1:0] emit_idx_q;
  logic [5:0]    rdata_q;
  logic [5:0]    digit_mem [W];
  logic          out_valid_q;
  itoa_pkg::out_word_t out_word_q;

  logic [W-1:0]  in_val;
  logic          in_neg;
  logic [5:0]    in_radix;
  logic [6:0]    trial;
  logic          fits;

  assign in_val = in_word_i.value[W-1:0];
  assign in_neg = in_word_i.signed_mode & in_val[W-1];

  always_comb begin
    priority if (in_word_i.radix < itoa_pkg::RADIX_MIN) begin
      in_radix = itoa_pkg::RADIX_MIN;
    end else if (in_word_i.radix > itoa_pkg::RADIX_MAX) begin
      in_radix = itoa_pkg::RADIX_MAX;
    end else begin
      in_radix = in_word_i.radix;
    end
  end

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, quot_q[W-1]};
  assign fits  = (trial >= {1'b0, radix_q});

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    if (cmd_i.load) begin
      quot_d = in_neg ? (~in_val + 1'b1) : in_val;
      rem_d  = '0;
    end else if (cmd_i.div_step) begin
      quot_d = {quot_q[W-2:0], fits};
      rem_d  = fits ? 6'(trial - {1'b0, radix_q}) : trial[5:0];
    end else if (cmd_i.digit_wr) begin
      rem_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (cmd_i.load) begin
      radix_q <= in_radix;
      neg_q   <= in_neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_cnt_q   <= '0;
      emit_idx_q <= '0;
    end else if (cmd_i.load) begin
      wr_cnt_q <= '0;
    end else if (cmd_i.digit_wr) begin
      wr_cnt_q   <= wr_cnt_q + 1'b1;
      emit_idx_q <= wr_cnt_q[IW-1:0];
    end else if (cmd_i.emit_ld) begin
      emit_idx_q <= emit_idx_q - 1'b1;
    end
  end

  // digit buffer, least significant digit at index 0
  always_ff @(posedge clk_i) begin
    if (cmd_i.digit_wr) begin
      digit_mem[wr_cnt_q[IW-1:0]] <= rem_q;
    end
    if (cmd_i.emit_rd) begin
      rdata_q <= digit_mem[emit_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ld) begin
      out_word_q.character <= itoa_pkg::digit_char(rdata_q);
      out_word_q.negative  <= neg_q;
      out_word_q.last      <= (emit_idx_q == '0);
    end
  end

  assign status_o.quot_zero = (quot_q == '0);
  assign status_o.emit_last = (emit_idx_q == '0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== hdl/integer_to_ascii_radix.sv =====
// channel | direction | handshake              | word
// --------+-----------+------------------------+-----------------------------
// in      | input     | in_valid_i / in_ready_o   | in_word_i  (value, mode, radix)
// out     | output    | out_valid_o / out_ready_i | out_word_o (char, neg, last)
//
// Each digit is the remainder of a full pass of the shared one-bit restoring
// divider and is then stored; emission reads each digit from the buffer and
// then loads it into the output register. One item at a time; the next is
// accepted once its last digit sits in the output register. A stalled output
// holds the emitter. Reset (rst_ni low, async) clears control state only.
module integer_to_ascii_radix #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  itoa_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output itoa_pkg::out_word_t out_word_o
);

  itoa_pkg::dp_cmd_t    cmd;
  itoa_pkg::dp_status_t status;

  itoa_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  itoa_dpath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

endmodule

// ===== hdl/itoa_checker.sv =====
module itoa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input itoa_pkg::out_word_t out_word_o
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // no new item while a conversion still has digits to deliver
  a_busy_mid_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.last |-> !in_ready_o)
    else $error("input ready in the middle of a digit string");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accept");

  // an accept is not followed at once by a new output digit
  a_no_early_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("digit appeared before any division");

endmodule

bind integer_to_ascii_radix itoa_checker u_itoa_checker (.*);
